/* hw/rtl/sta_pkg.sv */
// Shared types and constants for the sample to ASCII frame unit.
// No dependencies; sta_framer and the top unit refer to it by scoped names.
`default_nettype none

package sta_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_SLOPE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_OFFSET = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SHIFT  = 2'd2;

  localparam logic [7:0]  SLOPE_RST  = 8'd56;
  localparam logic [15:0] OFFSET_RST = 16'd27891;
  localparam logic [3:0]  SHIFT_RST  = 4'd7;

  localparam int          ValueW  = 14;
  localparam logic [13:0] SAT_MAX = 14'd9999;

  localparam logic [7:0] CH_STX  = 8'h02;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ETX  = 8'h03;
  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef enum logic [2:0] {
    SLOT_STX,
    SLOT_D3,
    SLOT_DOT,
    SLOT_D2,
    SLOT_D1,
    SLOT_D0,
    SLOT_CR,
    SLOT_ETX
  } frame_slot_t;

  typedef struct packed {
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } digits_t;

endpackage

`default_nettype wire

/* hw/rtl/sta_in_if.sv */
// Input channel of the sample to ASCII frame unit: valid, ready and one sample.
// No dependencies.
`default_nettype none

interface sta_in_if #(
  parameter int SampleBits = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sta_out_if.sv */
// Result channel of the sample to ASCII frame unit: valid, ready, one frame byte and a last-byte flag.
// No dependencies.
`default_nettype none

interface sta_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sta_framer.sv */
// Byte serializer: turns one set of four decimal digits into an eight-byte ASCII frame.
// Depends on sta_pkg and sta_out_if.
`default_nettype none

module sta_framer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             frm_valid,
  input  wire sta_pkg::digits_t frm_digits,
  output logic                  frm_ready,
  sta_out_if.source             out_ch
);

  logic                 busy_r;
  logic                 busy_nxt;
  sta_pkg::frame_slot_t slot_r;
  sta_pkg::frame_slot_t slot_nxt;
  sta_pkg::digits_t     digits_r;
  logic                 out_fire;
  logic                 load;

  assign out_fire  = out_ch.valid && out_ch.ready;
  assign frm_ready = !busy_r || (out_fire && (slot_r == sta_pkg::SLOT_ETX));
  assign load      = frm_valid && frm_ready;

  always_comb begin
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    if (load) begin
      busy_nxt = 1'b1;
      slot_nxt = sta_pkg::SLOT_STX;
    end else if (out_fire) begin
      if (slot_r == sta_pkg::SLOT_ETX) begin
        busy_nxt = 1'b0;
        slot_nxt = sta_pkg::SLOT_STX;
      end else begin
        slot_nxt = sta_pkg::frame_slot_t'(slot_r + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= sta_pkg::SLOT_STX;
    end else begin
      busy_r <= busy_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits_r <= frm_digits;
    end
  end

  assign out_ch.valid      = busy_r;
  assign out_ch.frame_last = (slot_r == sta_pkg::SLOT_ETX);

  always_comb begin
    case (slot_r)
      sta_pkg::SLOT_STX: out_ch.frame_byte = sta_pkg::CH_STX;
      sta_pkg::SLOT_D3:  out_ch.frame_byte = sta_pkg::CH_ZERO + {4'd0, digits_r.d3};
      sta_pkg::SLOT_DOT: out_ch.frame_byte = sta_pkg::CH_DOT;
      sta_pkg::SLOT_D2:  out_ch.frame_byte = sta_pkg::CH_ZERO + {4'd0, digits_r.d2};
      sta_pkg::SLOT_D1:  out_ch.frame_byte = sta_pkg::CH_ZERO + {4'd0, digits_r.d1};
      sta_pkg::SLOT_D0:  out_ch.frame_byte = sta_pkg::CH_ZERO + {4'd0, digits_r.d0};
      sta_pkg::SLOT_CR:  out_ch.frame_byte = sta_pkg::CH_CR;
      sta_pkg::SLOT_ETX: out_ch.frame_byte = sta_pkg::CH_ETX;
      default:           out_ch.frame_byte = sta_pkg::CH_ETX;
    endcase
  end

  a_last_is_etx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_last) |-> (out_ch.frame_byte == sta_pkg::CH_ETX))
    else $error("frame_last set on a byte other than ETX");

  a_slot_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && (slot_r != sta_pkg::SLOT_ETX)) |=>
      (busy_r && (slot_r == sta_pkg::frame_slot_t'($past(slot_r) + 3'd1))))
    else $error("frame byte position did not advance after a transaction");

  a_load_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (busy_r && (slot_r == sta_pkg::SLOT_STX)))
    else $error("new frame did not start at STX");

endmodule

`default_nettype wire

/* hw/rtl/sample_to_ascii_frame_unit.sv */
// Sample to ASCII frame unit: calibrates a converter sample as
// (slope * sample + offset) >> shift_amount, limits it to 9999 and sends it as an
// eight-byte frame STX d.ddd CR ETX with the last byte flagged. A sample goes through
// five register stages (multiply, add/shift/saturate, thousands, hundreds, tens and
// ones) before reaching the byte serializer. The serializer emits one byte per cycle
// while the output is ready and takes the next frame in the cycle its ETX byte
// leaves; while a frame is being sent, up to five further samples wait in the stages.
// Depends on sta_pkg, sta_in_if, sta_out_if and sta_framer.
`default_nettype none

module sample_to_ascii_frame_unit #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  sta_in_if.sink                            in_ch,
  sta_out_if.source                         out_ch,
  input  wire logic                         cfg_wr_en,
  input  wire logic [sta_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [sta_pkg::CfgDataW-1:0] cfg_wdata
);

  localparam int ProdW = SAMPLE_BITS + 8;
  localparam int SumW  = ProdW + 1;

  logic [7:0]  slope_r;
  logic [15:0] offset_r;
  logic [3:0]  shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r  <= sta_pkg::SLOPE_RST;
      offset_r <= sta_pkg::OFFSET_RST;
      shift_r  <= sta_pkg::SHIFT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sta_pkg::REG_SLOPE:  slope_r  <= cfg_wdata[7:0];
        sta_pkg::REG_OFFSET: offset_r <= cfg_wdata[15:0];
        sta_pkg::REG_SHIFT:  shift_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  logic                      s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  logic                      en1, en2, en3, en4, en5;
  logic [ProdW-1:0]          s1_prod_r;
  logic [sta_pkg::ValueW-1:0] s2_value_r;
  logic [3:0]                s3_d3_r;
  logic [9:0]                s3_rem_r;
  logic [3:0]                s4_d3_r, s4_d2_r;
  logic [6:0]                s4_rem_r;
  sta_pkg::digits_t          s5_digits_r;
  logic                      frm_ready;

  logic [SAMPLE_BITS-1:0]     sample;
  logic [ProdW-1:0]           prod_nxt;
  logic [SumW-1:0]            sum;
  logic [SumW-1:0]            shifted;
  logic [sta_pkg::ValueW-1:0] value_nxt;
  logic [3:0]                 d3_nxt, d2_nxt, d1_nxt;
  logic [13:0]                sub3;
  logic [9:0]                 sub2;
  logic [6:0]                 sub1;
  logic [9:0]                 rem3_nxt;
  logic [6:0]                 rem2_nxt;
  logic [3:0]                 d0_nxt;

  assign en5 = !s5_valid_r || frm_ready;
  assign en4 = !s4_valid_r || en5;
  assign en3 = !s3_valid_r || en4;
  assign en2 = !s2_valid_r || en3;
  assign en1 = !s1_valid_r || en2;
  assign in_ch.ready = en1;

  assign sample   = SAMPLE_BITS'(in_ch.adc_sample);
  assign prod_nxt = ProdW'(slope_r) * ProdW'(sample);

  always_comb begin
    sum     = SumW'(s1_prod_r) + SumW'(offset_r);
    shifted = sum >> shift_r;
    if (shifted > SumW'(sta_pkg::SAT_MAX)) begin
      value_nxt = sta_pkg::SAT_MAX;
    end else begin
      value_nxt = sta_pkg::ValueW'(shifted);
    end
  end

  always_comb begin
    d3_nxt = 4'd0;
    sub3   = 14'd0;
    for (int k = 1; k <= 9; k++) begin
      if (s2_value_r >= 14'(k * 1000)) begin
        d3_nxt = 4'(k);
        sub3   = 14'(k * 1000);
      end
    end
    rem3_nxt = 10'(s2_value_r - sub3);
  end

  always_comb begin
    d2_nxt = 4'd0;
    sub2   = 10'd0;
    for (int k = 1; k <= 9; k++) begin
      if (s3_rem_r >= 10'(k * 100)) begin
        d2_nxt = 4'(k);
        sub2   = 10'(k * 100);
      end
    end
    rem2_nxt = 7'(s3_rem_r - sub2);
  end

  always_comb begin
    d1_nxt = 4'd0;
    sub1   = 7'd0;
    for (int k = 1; k <= 9; k++) begin
      if (s4_rem_r >= 7'(k * 10)) begin
        d1_nxt = 4'(k);
        sub1   = 7'(k * 10);
      end
    end
    d0_nxt = 4'(s4_rem_r - sub1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r <= in_ch.valid;
      if (en2) s2_valid_r <= s1_valid_r;
      if (en3) s3_valid_r <= s2_valid_r;
      if (en4) s4_valid_r <= s3_valid_r;
      if (en5) s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_prod_r <= prod_nxt;
    end
    if (en2) begin
      s2_value_r <= value_nxt;
    end
    if (en3) begin
      s3_d3_r  <= d3_nxt;
      s3_rem_r <= rem3_nxt;
    end
    if (en4) begin
      s4_d3_r  <= s3_d3_r;
      s4_d2_r  <= d2_nxt;
      s4_rem_r <= rem2_nxt;
    end
    if (en5) begin
      s5_digits_r.d3 <= s4_d3_r;
      s5_digits_r.d2 <= s4_d2_r;
      s5_digits_r.d1 <= d1_nxt;
      s5_digits_r.d0 <= d0_nxt;
    end
  end

  sta_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .frm_valid  (s5_valid_r),
    .frm_digits (s5_digits_r),
    .frm_ready  (frm_ready),
    .out_ch     (out_ch)
  );

  a_value_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (s2_value_r <= sta_pkg::SAT_MAX))
    else $error("scaled value above 9999 after saturation");

  a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    s5_valid_r |-> ((s5_digits_r.d3 <= 4'd9) && (s5_digits_r.d2 <= 4'd9) &&
                    (s5_digits_r.d1 <= 4'd9) && (s5_digits_r.d0 <= 4'd9)))
    else $error("digit out of decimal range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_valid_r && !frm_ready) |=> (s5_valid_r && $stable(s5_digits_r)))
    else $error("stalled digits were lost or changed");

endmodule

`default_nettype wire
